// File: design/spq_pkg.sv
// Shared types, codes and default sizes for the strict priority pool queue.
`default_nettype none
package spq_pkg;

  localparam int POOL_ENTRIES_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 64;
  localparam int NUM_CLASSES_DEF  = 3;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request control fields as held in the input register.
  typedef struct packed {
    opcode_t    opcode;
    logic [1:0] cls;
  } spq_op_t;

  // Result control fields handed to the result register.
  typedef struct packed {
    status_t    status;
    logic [1:0] served_class;
    logic [4:0] held_count;
  } spq_res_t;

endpackage
`default_nettype wire

// File: design/spq_if.sv
// Request and response channel interfaces of the strict priority pool queue.
`default_nettype none
interface spq_req_if #(parameter int DATA_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [1:0]            priority_class;
  logic [DATA_WIDTH-1:0] payload;

  modport source (output valid, output opcode, output priority_class, output payload,
                  input ready);
  modport sink   (input valid, input opcode, input priority_class, input payload,
                  output ready);
endinterface

interface spq_rsp_if #(parameter int DATA_WIDTH = 64);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] out_payload;
  logic [1:0]            served_class;
  logic [4:0]            held_count;

  modport source (output valid, output status, output out_payload, output served_class,
                  output held_count, input ready);
  modport sink   (input valid, input status, input out_payload, input served_class,
                  input held_count, output ready);
endinterface
`default_nettype wire

// File: design/spq_link_mem.sv
// Next-pointer memory: one write port, two registered read ports with write forwarding.
`default_nettype none
module spq_link_mem #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [$clog2(DEPTH)-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [$clog2(DEPTH)-1:0] rdata_a,
  output logic      [$clog2(DEPTH)-1:0] rdata_b
);
  localparam int IW = $clog2(DEPTH);

  logic [IW-1:0] mem_r [DEPTH];
  logic [IW-1:0] rdata_a_r;
  logic [IW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // forward the word written in this cycle
    rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem_r[raddr_a];
    rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;
endmodule
`default_nettype wire

// File: design/spq_data_mem.sv
// Message word memory: one write port, one registered read port with write forwarding.
`default_nettype none
module spq_data_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= (we && (waddr == raddr)) ? wdata : mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: design/spq_ctrl.sv
// Queue pointer state, free list and per-request next-state logic.
`default_nettype none
module spq_ctrl #(
  parameter int POOL_ENTRIES = 16,
  parameter int DATA_WIDTH   = 64,
  parameter int NUM_CLASSES  = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            fire,
  input  wire spq_pkg::spq_op_t                op,
  input  wire logic [DATA_WIDTH-1:0]           op_payload,
  output spq_pkg::spq_res_t                    res,
  output logic      [DATA_WIDTH-1:0]           res_payload,
  output logic                                 link_we,
  output logic      [$clog2(POOL_ENTRIES)-1:0] link_waddr,
  output logic      [$clog2(POOL_ENTRIES)-1:0] link_wdata,
  output logic      [$clog2(POOL_ENTRIES)-1:0] link_raddr_free,
  output logic      [$clog2(POOL_ENTRIES)-1:0] link_raddr_head,
  input  wire logic [$clog2(POOL_ENTRIES)-1:0] link_rdata_free,
  input  wire logic [$clog2(POOL_ENTRIES)-1:0] link_rdata_head,
  output logic                                 data_we,
  output logic      [$clog2(POOL_ENTRIES)-1:0] data_waddr,
  output logic      [DATA_WIDTH-1:0]           data_wdata,
  output logic      [$clog2(POOL_ENTRIES)-1:0] data_raddr,
  input  wire logic [DATA_WIDTH-1:0]           data_rdata
);
  import spq_pkg::*;

  localparam int IW  = $clog2(POOL_ENTRIES);
  localparam int CW  = $clog2(POOL_ENTRIES + 1);
  localparam int CLW = $clog2(NUM_CLASSES);

  logic [IW-1:0]          heads_r  [NUM_CLASSES];
  logic [IW-1:0]          heads_nxt[NUM_CLASSES];
  logic [IW-1:0]          tails_r  [NUM_CLASSES];
  logic [IW-1:0]          tails_nxt[NUM_CLASSES];
  logic [NUM_CLASSES-1:0] nonempty_r, nonempty_nxt;
  logic [IW-1:0]          free_head_r, free_head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  // entries below the watermark have been allocated at least once
  logic [CW-1:0]          wm_r, wm_nxt;

  logic [CLW-1:0] top;
  logic [CLW-1:0] top_nxt;
  logic [CLW-1:0] cls_c;
  logic           fresh;
  logic [IW-1:0]  fresh_link;
  logic [IW-1:0]  e;

  function automatic logic [CLW-1:0] first_set(input logic [NUM_CLASSES-1:0] v);
    logic [CLW-1:0] idx;
    idx = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = CLW'(i);
      end
    end
    return idx;
  endfunction

  assign top        = first_set(nonempty_r);
  assign fresh      = (CW'(free_head_r) >= wm_r);
  assign fresh_link = (free_head_r == IW'(POOL_ENTRIES - 1)) ? '0 : free_head_r + 1'b1;
  assign cls_c      = (int'(op.cls) >= NUM_CLASSES) ? CLW'(NUM_CLASSES - 1) : CLW'(op.cls);

  always_comb begin
    heads_nxt     = heads_r;
    tails_nxt     = tails_r;
    nonempty_nxt  = nonempty_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    wm_nxt        = wm_r;
    link_we       = 1'b0;
    link_waddr    = free_head_r;
    link_wdata    = free_head_r;
    data_we       = 1'b0;
    data_waddr    = free_head_r;
    data_wdata    = op_payload;
    res.status       = ST_DONE;
    res.served_class = '0;
    res_payload      = '0;
    e                = free_head_r;
    if (fire) begin
      unique case (op.opcode)
        OP_ENQ: begin
          if (count_r == CW'(POOL_ENTRIES)) begin
            res.status = ST_FULL;
          end else begin
            e             = free_head_r;
            free_head_nxt = fresh ? fresh_link : link_rdata_free;
            if (fresh) begin
              wm_nxt = wm_r + 1'b1;
            end
            data_we = 1'b1;
            if (nonempty_r[cls_c]) begin
              link_we           = 1'b1;
              link_waddr        = tails_r[cls_c];
              link_wdata        = e;
              tails_nxt[cls_c]  = e;
            end else begin
              heads_nxt[cls_c]    = e;
              tails_nxt[cls_c]    = e;
              nonempty_nxt[cls_c] = 1'b1;
            end
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEQ: begin
          if (nonempty_r == '0) begin
            res.status = ST_EMPTY;
          end else begin
            e                = heads_r[top];
            res_payload      = data_rdata;
            res.served_class = 2'(top);
            if (e == tails_r[top]) begin
              nonempty_nxt[top] = 1'b0;
            end else begin
              heads_nxt[top] = link_rdata_head;
            end
            // push the freed entry onto the free list
            link_we       = 1'b1;
            link_waddr    = e;
            link_wdata    = free_head_r;
            free_head_nxt = e;
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end
        default: begin
          res.status = ST_DONE;
        end
      endcase
    end
    res.held_count = 5'(count_nxt);
  end

  // Prefetch for the next request from the state this cycle leaves behind.
  assign top_nxt         = first_set(nonempty_nxt);
  assign link_raddr_free = free_head_nxt;
  assign link_raddr_head = heads_nxt[top_nxt];
  assign data_raddr      = heads_nxt[top_nxt];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_r[i] <= '0;
        tails_r[i] <= '0;
      end
      nonempty_r  <= '0;
      free_head_r <= '0;
      count_r     <= '0;
      wm_r        <= '0;
    end else begin
      heads_r     <= heads_nxt;
      tails_r     <= tails_nxt;
      nonempty_r  <= nonempty_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      wm_r        <= wm_nxt;
    end
  end
endmodule
`default_nettype wire

// File: design/strict_priority_pool_queue.sv
// Strict priority pool queue: three-class linked-list FIFOs sharing one entry pool.
// Response path: a request is held in the input reg, its result in the result reg.
// Throughput: one request per cycle unless out_rsp stalls; link and payload memories
// are read ahead at the next-state free head and top-class head: one pass per request.
// Reset (synchronous): clears pointers, counts and valids; the initial free chain is
// tracked by an allocation watermark, so no memory clearing pass is run.
`default_nettype none
module strict_priority_pool_queue #(
  parameter int POOL_ENTRIES = spq_pkg::POOL_ENTRIES_DEF,
  parameter int DATA_WIDTH   = spq_pkg::DATA_WIDTH_DEF,
  parameter int NUM_CLASSES  = spq_pkg::NUM_CLASSES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  spq_req_if.sink   in_req,
  spq_rsp_if.source out_rsp
);
  import spq_pkg::*;

  localparam int IW = $clog2(POOL_ENTRIES);

  logic                  in_valid_r;
  spq_op_t               op_r;
  logic [DATA_WIDTH-1:0] in_payload_r;
  logic                  out_valid_r;
  spq_res_t              res_r;
  logic [DATA_WIDTH-1:0] out_payload_r;
  logic                  fire;
  spq_res_t              res;
  logic [DATA_WIDTH-1:0] res_payload;

  logic          link_we;
  logic [IW-1:0] link_waddr, link_wdata, link_raddr_free, link_raddr_head;
  logic [IW-1:0] link_rdata_free, link_rdata_head;
  logic                  data_we;
  logic [IW-1:0]         data_waddr, data_raddr;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

  assign fire         = in_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_req.ready) begin
        in_valid_r <= in_req.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      op_r.opcode  <= opcode_t'(in_req.opcode);
      op_r.cls     <= in_req.priority_class;
      in_payload_r <= in_req.payload;
    end
    if (fire) begin
      res_r         <= res;
      out_payload_r <= res_payload;
    end
  end

  spq_ctrl #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .DATA_WIDTH  (DATA_WIDTH),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .op             (op_r),
    .op_payload     (in_payload_r),
    .res            (res),
    .res_payload    (res_payload),
    .link_we        (link_we),
    .link_waddr     (link_waddr),
    .link_wdata     (link_wdata),
    .link_raddr_free(link_raddr_free),
    .link_raddr_head(link_raddr_head),
    .link_rdata_free(link_rdata_free),
    .link_rdata_head(link_rdata_head),
    .data_we        (data_we),
    .data_waddr     (data_waddr),
    .data_wdata     (data_wdata),
    .data_raddr     (data_raddr),
    .data_rdata     (data_rdata)
  );

  spq_link_mem #(
    .DEPTH(POOL_ENTRIES)
  ) u_link_mem (
    .clk    (clk),
    .we     (link_we),
    .waddr  (link_waddr),
    .wdata  (link_wdata),
    .raddr_a(link_raddr_free),
    .raddr_b(link_raddr_head),
    .rdata_a(link_rdata_free),
    .rdata_b(link_rdata_head)
  );

  spq_data_mem #(
    .DEPTH(POOL_ENTRIES),
    .WIDTH(DATA_WIDTH)
  ) u_data_mem (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = res_r.status;
  assign out_rsp.served_class = res_r.served_class;
  assign out_rsp.held_count   = res_r.held_count;
  assign out_rsp.out_payload  = out_payload_r;
endmodule
`default_nettype wire

// File: design/spq_checker.sv
// Port-level checker for the strict priority pool queue and its bind.
`default_nettype none
module spq_checker #(
  parameter int POOL_ENTRIES = 16,
  parameter int DATA_WIDTH   = 64
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            out_status,
  input wire logic [DATA_WIDTH-1:0] out_payload,
  input wire logic [1:0]            out_served_class,
  input wire logic [4:0]            out_held_count
);
  import spq_pkg::*;

  // reset drops any pending response
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_payload) && $stable(out_served_class) && $stable(out_held_count))
    else $error("stalled response changed");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_held_count == 5'(POOL_ENTRIES))
    else $error("pool full reported with free entries");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_held_count == '0) && (out_payload == '0) && (out_served_class == '0))
    else $error("empty reported while messages held");
endmodule

bind strict_priority_pool_queue spq_checker #(
  .POOL_ENTRIES(POOL_ENTRIES),
  .DATA_WIDTH  (DATA_WIDTH)
) u_spq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_rsp.valid),
  .out_ready       (out_rsp.ready),
  .out_status      (out_rsp.status),
  .out_payload     (out_rsp.out_payload),
  .out_served_class(out_rsp.served_class),
  .out_held_count  (out_rsp.held_count)
);
`default_nettype wire
